// ===== hw/rtl/float_to_decimal_text_macros.svh =====
// Assertion helpers used by the float_to_decimal_text RTL.
`ifndef FLOAT_TO_DECIMAL_TEXT_MACROS_SVH
`define FLOAT_TO_DECIMAL_TEXT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define FTDT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define FTDT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ftdt_pkg.sv =====
// ----------------------------------------------------------------------------
// ftdt_pkg
// Types, constants and helpers for the float to decimal text block.
// ----------------------------------------------------------------------------
`default_nettype none

package ftdt_pkg;

  localparam int unsigned MaxFractionDigits = 9;
  localparam int unsigned NumDigits         = 10;

  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharPoint = 7'h2e;
  localparam logic [6:0] CharMinus = 7'h2d;

  typedef struct packed {
    logic [31:0] value_bits;
    logic [3:0]  fraction_digits;
  } in_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
    logic       overflow;
  } out_t;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StNorm,
    StRound,
    StScale,
    StBcd,
    StEmit,
    StOvf
  } state_e;

  // 5^p, p in 0..9; 10^p = 5^p * 2^p
  function automatic logic [20:0] pow5(input logic [3:0] p);
    logic [20:0] r;
    unique case (p)
      4'd0:    r = 21'd1;
      4'd1:    r = 21'd5;
      4'd2:    r = 21'd25;
      4'd3:    r = 21'd125;
      4'd4:    r = 21'd625;
      4'd5:    r = 21'd3125;
      4'd6:    r = 21'd15625;
      4'd7:    r = 21'd78125;
      4'd8:    r = 21'd390625;
      default: r = 21'd1953125;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ftdt_bcd.sv =====
// ----------------------------------------------------------------------------
// ftdt_bcd
// Bit-serial binary to BCD converter (shift and add-3); a start restarts any conversion in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module ftdt_bcd (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] bin_i,
  output logic             done_o,
  output logic [39:0]      digits_o
);

  logic [31:0] shreg_q, shreg_d;
  logic [39:0] bcd_q, bcd_d;
  logic [39:0] adj;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  always_comb begin
    for (int i = 0; i < ftdt_pkg::NumDigits; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
    end
  end

  always_comb begin
    shreg_d = shreg_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      shreg_d = bin_i;
      bcd_d   = '0;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      bcd_d   = {adj[38:0], shreg_q[31]};
      shreg_d = {shreg_q[30:0], 1'b0};
      cnt_d   = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    bcd_q   <= bcd_d;
  end

  assign done_o   = done_q;
  assign digits_o = bcd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/float_to_decimal_text.sv =====
// Converts a single-precision value and a digit count P (saturated at 9) into
// fixed-point decimal ASCII text, one character per output item, with last on
// the final one. One value is handled at a time. The stages are: a 24x21
// multiply, a one-bit-per-cycle rounding normalize (up to 21 shifts), a
// one-bit-per-cycle scaling shift (up to 25 shifts) and a shift-and-add-3
// BCD conversion. After that comes one character per cycle (up to 12) while
// the output is not stalled. The next item is taken in the cycle after the
// last character is loaded. NaN, infinity and scaled magnitudes at or above
// 2^32 give one overflow item, sooner.
// ----------------------------------------------------------------------------
// float_to_decimal_text
// Float to fixed-point decimal text converter, top level.
// ----------------------------------------------------------------------------
`default_nettype none

module float_to_decimal_text (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire ftdt_pkg::in_t    in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ftdt_pkg::out_t        out_data_o
);

  `include "float_to_decimal_text_macros.svh"

  ftdt_pkg::state_e state_q, state_d;

  logic [3:0]        p_q, p_d;
  logic              neg_q, neg_d;
  logic [23:0]       mant_q, mant_d;
  logic [44:0]       m_q, m_d;
  logic signed [9:0] e_q, e_d;
  logic              rnd_q, rnd_d, stk_q, stk_d;
  logic [3:0]        pos_q, pos_d;
  logic              dot_q, dot_d, negp_q, negp_d;
  logic              out_valid_q, out_valid_d;
  ftdt_pkg::out_t    out_q, out_d;

  logic [20:0] pow5_w;
  logic [44:0] prod;
  logic        bcd_start, bcd_done;
  logic [39:0] digits;
  logic [3:0]  top, p_sat;
  logic [7:0]  expv;
  logic        load_ok;

  assign pow5_w = ftdt_pkg::pow5(p_q);
  assign prod   = mant_q * pow5_w;

  ftdt_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bcd_start),
    .bin_i    (m_q[31:0]),
    .done_o   (bcd_done),
    .digits_o (digits)
  );

  always_comb begin
    top = '0;
    for (int i = 1; i < ftdt_pkg::NumDigits; i++) begin
      if (digits[i*4 +: 4] != 4'd0) top = 4'(i);
    end
  end

  assign expv    = in_data_i.value_bits[30:23];
  assign p_sat   = (in_data_i.fraction_digits > 4'(ftdt_pkg::MaxFractionDigits)) ?
                   4'(ftdt_pkg::MaxFractionDigits) : in_data_i.fraction_digits;
  assign load_ok = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    neg_d       = neg_q;
    mant_d      = mant_q;
    m_d         = m_q;
    e_d         = e_q;
    rnd_d       = rnd_q;
    stk_d       = stk_q;
    pos_d       = pos_q;
    dot_d       = dot_q;
    negp_d      = negp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    bcd_start   = 1'b0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ftdt_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          p_d    = p_sat;
          neg_d  = in_data_i.value_bits[31] && (in_data_i.value_bits[30:0] != 31'd0);
          mant_d = {(expv != 8'd0), in_data_i.value_bits[22:0]};
          e_d    = 10'((expv != 8'd0) ? expv : 8'd1) - 10'sd150 + 10'(p_sat);
          state_d = (expv == 8'hff) ? ftdt_pkg::StOvf : ftdt_pkg::StMul;
        end
      end
      ftdt_pkg::StMul: begin
        m_d     = prod;
        rnd_d   = 1'b0;
        stk_d   = 1'b0;
        state_d = ftdt_pkg::StNorm;
      end
      ftdt_pkg::StNorm: begin
        // keep 24 significant bits, collecting guard and sticky
        if (m_q[44:24] != '0) begin
          stk_d = stk_q | rnd_q;
          rnd_d = m_q[0];
          m_d   = {1'b0, m_q[44:1]};
          e_d   = e_q + 10'sd1;
        end else begin
          state_d = ftdt_pkg::StRound;
        end
      end
      ftdt_pkg::StRound: begin
        if (rnd_q && (stk_q || m_q[0])) m_d = m_q + 45'd1;
        state_d = ftdt_pkg::StScale;
      end
      ftdt_pkg::StScale: begin
        if (m_q == '0 || e_q == 10'sd0) begin
          bcd_start = 1'b1;
          state_d   = ftdt_pkg::StBcd;
        end else if (e_q > 10'sd0) begin
          if (m_q[44:31] != '0) begin
            state_d = ftdt_pkg::StOvf;
          end else begin
            m_d = {m_q[43:0], 1'b0};
            e_d = e_q - 10'sd1;
          end
        end else begin
          m_d = {1'b0, m_q[44:1]};
          e_d = e_q + 10'sd1;
        end
      end
      ftdt_pkg::StBcd: begin
        if (bcd_done) begin
          pos_d   = (top > p_q) ? top : p_q;
          negp_d  = neg_q;
          dot_d   = 1'b0;
          state_d = ftdt_pkg::StEmit;
        end
      end
      ftdt_pkg::StEmit: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          priority if (negp_q) begin
            out_d  = '{character: ftdt_pkg::CharMinus, last: 1'b0, overflow: 1'b0};
            negp_d = 1'b0;
          end else if (p_q != 4'd0 && pos_q == p_q - 4'd1 && !dot_q) begin
            out_d = '{character: ftdt_pkg::CharPoint, last: 1'b0, overflow: 1'b0};
            dot_d = 1'b1;
          end else begin
            out_d = '{character: ftdt_pkg::CharZero + 7'(digits[pos_q*4 +: 4]),
                      last: (pos_q == 4'd0), overflow: 1'b0};
            if (pos_q == 4'd0) state_d = ftdt_pkg::StIdle;
            else pos_d = pos_q - 4'd1;
          end
        end
      end
      ftdt_pkg::StOvf: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          out_d       = '{character: 7'd0, last: 1'b1, overflow: 1'b1};
          state_d     = ftdt_pkg::StIdle;
        end
      end
      default: state_d = ftdt_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ftdt_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    neg_q  <= neg_d;
    mant_q <= mant_d;
    m_q    <= m_d;
    e_q    <= e_d;
    rnd_q  <= rnd_d;
    stk_q  <= stk_d;
    pos_q  <= pos_d;
    dot_q  <= dot_d;
    negp_q <= negp_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FTDT_ASSERT_IMP(a_ovf_form, clk_i, rst_ni, out_valid_o && out_data_o.overflow, out_data_o.last && out_data_o.character == 7'd0, "overflow item malformed")
  `FTDT_ASSERT_IMP(a_bcd_done_state, clk_i, rst_ni, bcd_done, state_q == ftdt_pkg::StBcd, "bcd done outside conversion")
  `FTDT_ASSERT_NXT(a_round_width, clk_i, rst_ni, state_q == ftdt_pkg::StRound, m_q[44:25] == '0, "rounded significand too wide")

endmodule

`default_nettype wire
